// ===== rtl/gpio_exti_pkg.sv =====
// Shared types, register codes and pin masks for the GPIO port with edge interrupts.
`timescale 1ns / 1ps

package gpio_exti_pkg;

  // Number of implemented pins (1 to 16)
  localparam int PIN_COUNT = 16;

  // Field widths fixed by the bus format
  localparam int KIND_W   = 2;
  localparam int INDEX_W  = 4;
  localparam int WORD_W   = 32;
  localparam int PINS_W   = 16;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 72;

  // Write masks that keep bits of pins beyond PIN_COUNT at zero
  localparam logic [PINS_W-1:0] PIN_MASK  = PINS_W'((64'd1 << PIN_COUNT) - 64'd1);
  localparam logic [WORD_W-1:0] PAIR_MASK = WORD_W'((64'd1 << (2 * PIN_COUNT)) - 64'd1);
  localparam int AF0_BITS = 4 * ((PIN_COUNT > 8) ? 8 : PIN_COUNT);
  localparam int AF1_BITS = (PIN_COUNT > 8) ? 4 * (PIN_COUNT - 8) : 0;
  localparam logic [WORD_W-1:0] AF0_MASK = WORD_W'((64'd1 << AF0_BITS) - 64'd1);
  localparam logic [WORD_W-1:0] AF1_MASK = WORD_W'((64'd1 << AF1_BITS) - 64'd1);

  // Mode code of a general purpose output pin
  localparam logic [1:0] MODE_OUTPUT = 2'b01;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_SAMPLE = 2'd2
  } kind_t;

  // Register map
  typedef enum logic [INDEX_W-1:0] {
    REG_MODE    = 4'd0,
    REG_OTYPE   = 4'd1,
    REG_SPEED   = 4'd2,
    REG_PULL    = 4'd3,
    REG_IDR     = 4'd4,
    REG_ODR     = 4'd5,
    REG_AFL     = 4'd6,
    REG_AFH     = 4'd7,
    REG_IMR     = 4'd8,
    REG_RISE    = 4'd9,
    REG_FALL    = 4'd10,
    REG_PENDING = 4'd11
  } reg_t;

  // One input item
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] reg_index;
    logic [WORD_W-1:0]  write_data;
    logic [PINS_W-1:0]  pin_levels;
  } item_t;

  // One result item
  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic [PINS_W-1:0] pad_out;
    logic [PINS_W-1:0] pad_drive_enable;
    logic              irq;
    logic              bad_address;
  } result_t;

endpackage

// ===== rtl/gpio_exti_in_stage.sv =====
// Input register stage: holds one accepted item until the register file consumes it.
`timescale 1ns / 1ps

module gpio_exti_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gpio_exti_pkg::item_t in_item,
  input  logic                 out_busy,
  output logic                 advance,
  output gpio_exti_pkg::item_t item
);
  import gpio_exti_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // Move the held item on when the result register is free or being emptied
  assign advance  = valid_r && !out_busy;
  assign in_ready = !valid_r || advance;
  assign item     = item_r;

  // Track occupancy
  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== rtl/gpio_exti_regs.sv =====
// Port register file, edge detector and result computation for one item.
`timescale 1ns / 1ps

module gpio_exti_regs (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   advance,
  input  gpio_exti_pkg::item_t   item,
  output gpio_exti_pkg::result_t result
);
  import gpio_exti_pkg::*;

  logic [WORD_W-1:0] mode_r, mode_nxt;
  logic [PINS_W-1:0] otype_r, otype_nxt;
  logic [WORD_W-1:0] speed_r, speed_nxt;
  logic [WORD_W-1:0] pull_r, pull_nxt;
  logic [PINS_W-1:0] odr_r, odr_nxt;
  logic [WORD_W-1:0] afl_r, afl_nxt;
  logic [WORD_W-1:0] afh_r, afh_nxt;
  logic [PINS_W-1:0] idr_r, idr_nxt;
  logic [PINS_W-1:0] prev_r, prev_nxt;
  logic [PINS_W-1:0] imr_r, imr_nxt;
  logic [PINS_W-1:0] rise_r, rise_nxt;
  logic [PINS_W-1:0] fall_r, fall_nxt;
  logic [PINS_W-1:0] pend_r, pend_nxt;

  logic [PINS_W-1:0] levels;
  logic [PINS_W-1:0] edges;
  logic              addr_ok;
  logic [WORD_W-1:0] rd_data;
  logic [PINS_W-1:0] drive_en;

  assign levels  = item.pin_levels & PIN_MASK;
  assign edges   = ((levels & ~prev_r & rise_r) | (prev_r & ~levels & fall_r)) & PIN_MASK;
  assign addr_ok = item.reg_index inside {[REG_MODE:REG_PENDING]};

  // Decode the item into read data and next register values
  always_comb begin
    mode_nxt  = mode_r;
    otype_nxt = otype_r;
    speed_nxt = speed_r;
    pull_nxt  = pull_r;
    odr_nxt   = odr_r;
    afl_nxt   = afl_r;
    afh_nxt   = afh_r;
    idr_nxt   = idr_r;
    prev_nxt  = prev_r;
    imr_nxt   = imr_r;
    rise_nxt  = rise_r;
    fall_nxt  = fall_r;
    pend_nxt  = pend_r;
    rd_data   = '0;
    case (item.kind)
      KIND_READ: begin
        case (item.reg_index)
          REG_MODE:    rd_data = mode_r;
          REG_OTYPE:   rd_data = {16'd0, otype_r};
          REG_SPEED:   rd_data = speed_r;
          REG_PULL:    rd_data = pull_r;
          REG_IDR:     rd_data = {16'd0, idr_r};
          REG_ODR:     rd_data = {16'd0, odr_r};
          REG_AFL:     rd_data = afl_r;
          REG_AFH:     rd_data = afh_r;
          REG_IMR:     rd_data = {16'd0, imr_r};
          REG_RISE:    rd_data = {16'd0, rise_r};
          REG_FALL:    rd_data = {16'd0, fall_r};
          REG_PENDING: rd_data = {16'd0, pend_r};
          default:     rd_data = '0;
        endcase
      end
      KIND_WRITE: begin
        case (item.reg_index)
          REG_MODE:    mode_nxt  = item.write_data & PAIR_MASK;
          REG_OTYPE:   otype_nxt = item.write_data[PINS_W-1:0] & PIN_MASK;
          REG_SPEED:   speed_nxt = item.write_data & PAIR_MASK;
          REG_PULL:    pull_nxt  = item.write_data & PAIR_MASK;
          REG_ODR:     odr_nxt   = item.write_data[PINS_W-1:0] & PIN_MASK;
          REG_AFL:     afl_nxt   = item.write_data & AF0_MASK;
          REG_AFH:     afh_nxt   = item.write_data & AF1_MASK;
          REG_IMR:     imr_nxt   = item.write_data[PINS_W-1:0] & PIN_MASK;
          REG_RISE:    rise_nxt  = item.write_data[PINS_W-1:0] & PIN_MASK;
          REG_FALL:    fall_nxt  = item.write_data[PINS_W-1:0] & PIN_MASK;
          // Write one to clear
          REG_PENDING: pend_nxt  = pend_r & ~(item.write_data[PINS_W-1:0] & PIN_MASK);
          // Input data is read only; unmapped indexes change nothing
          default:     ;
        endcase
      end
      KIND_SAMPLE: begin
        pend_nxt = pend_r | edges;
        idr_nxt  = levels;
        prev_nxt = levels;
      end
      default: ;
    endcase
  end

  // Flag output pins from the updated mode word
  always_comb begin
    drive_en = '0;
    for (int p = 0; p < PIN_COUNT; p++) begin
      drive_en[p] = (mode_nxt[2*p +: 2] == MODE_OUTPUT);
    end
  end

  // Result fields reflect the state after the item
  always_comb begin
    result.read_data        = rd_data;
    result.pad_out          = odr_nxt;
    result.pad_drive_enable = drive_en;
    result.irq              = |(pend_nxt & imr_nxt);
    result.bad_address      = (item.kind == KIND_READ || item.kind == KIND_WRITE) && !addr_ok;
  end

  // Commit state when the item advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      otype_r <= '0;
      speed_r <= '0;
      pull_r  <= '0;
      odr_r   <= '0;
      afl_r   <= '0;
      afh_r   <= '0;
      idr_r   <= '0;
      prev_r  <= '0;
      imr_r   <= '0;
      rise_r  <= '0;
      fall_r  <= '0;
      pend_r  <= '0;
    end else if (advance) begin
      mode_r  <= mode_nxt;
      otype_r <= otype_nxt;
      speed_r <= speed_nxt;
      pull_r  <= pull_nxt;
      odr_r   <= odr_nxt;
      afl_r   <= afl_nxt;
      afh_r   <= afh_nxt;
      idr_r   <= idr_nxt;
      prev_r  <= prev_nxt;
      imr_r   <= imr_nxt;
      rise_r  <= rise_nxt;
      fall_r  <= fall_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

// ===== rtl/gpio_exti_out_stage.sv =====
// Result register stage: holds one result item until the downstream side takes it.
`timescale 1ns / 1ps

module gpio_exti_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   advance,
  input  gpio_exti_pkg::result_t result,
  output logic                   busy,
  output logic                   out_valid,
  input  logic                   out_ready,
  output gpio_exti_pkg::result_t out_result
);
  import gpio_exti_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  // Full and not being taken this cycle
  assign busy       = valid_r && !out_ready;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  // Load on advance, drop once taken
  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result;
    end
  end

endmodule

// ===== rtl/gpio_exti_port_with_edge_interrupts_core.sv =====
// Empty compilation unit; the top level is in gpio_port_with_edge_interrupts_core.sv.
`timescale 1ns / 1ps

// ===== rtl/gpio_port_with_edge_interrupts_core.sv =====
// Input register, state update and result logic, then result register, to out_tvalid.
// Throughput: one item per cycle unless out_tready stalls the result register.
// The input register takes a new item while a finished result still waits downstream.
// Reset (rst_n low, synchronous): all port registers, pending bits and sampled levels
// clear to zero, both stages empty; in_tready is high in the first cycle after reset.
`timescale 1ns / 1ps

module gpio_port_with_edge_interrupts_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [3:0] reg_index, [35:4] write_data, [51:36] pin_levels, [55:52] zero
  input  logic [gpio_exti_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  logic [gpio_exti_pkg::KIND_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] read_data, [47:32] pad_out, [63:48] pad_drive_enable, [64] irq,
  // [65] bad_address, [71:66] zero
  output logic [gpio_exti_pkg::OUT_DATA_W-1:0] out_tdata
);
  import gpio_exti_pkg::*;

  item_t   in_item;
  item_t   item;
  result_t result;
  result_t out_result;
  logic    advance;
  logic    out_busy;

  // Unpack the stream payload
  always_comb begin
    in_item.kind       = in_tuser;
    in_item.reg_index  = in_tdata[3:0];
    in_item.write_data = in_tdata[35:4];
    in_item.pin_levels = in_tdata[51:36];
  end

  gpio_exti_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .out_busy (out_busy),
    .advance  (advance),
    .item     (item)
  );

  gpio_exti_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  gpio_exti_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .result     (result),
    .busy       (out_busy),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  // Pack the result payload
  assign out_tdata = {6'd0, out_result.bad_address, out_result.irq,
                      out_result.pad_drive_enable, out_result.pad_out,
                      out_result.read_data};

endmodule

// ===== rtl/gpio_exti_checker.sv =====
// Port-level checks for the GPIO port core, bound to the top level.
`timescale 1ns / 1ps

module gpio_exti_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Input only stalls when both stages are full and downstream is stalled
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without downstream back-pressure");

  // An unmapped access never returns data
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[65] |-> out_tdata[31:0] == 32'd0)
    else $error("bad address with nonzero read data");

  // Reset empties both stages
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

endmodule

bind gpio_port_with_edge_interrupts_core gpio_exti_checker u_gpio_exti_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/tb_gpio_port_with_edge_interrupts_core.sv =====
// Self-checking stream testbench for the GPIO port with edge interrupts.
`timescale 1ns / 1ps

module tb_gpio_port_with_edge_interrupts_core;
  import gpio_exti_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [KIND_W-1:0]  KIND_UNUSED = 2'd3;
  localparam logic [INDEX_W-1:0] REG_TOP     = 4'hF;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [KIND_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t golden;
  } directed_row_t;

  directed_row_t directed_rows[$];
  result_t       port_results_q[$];

  // Shadow copy of the port registers
  logic [WORD_W-1:0] mode_r, speed_r, pull_r, afr_lo, afr_hi;
  logic [PINS_W-1:0] otype_r, odr_r, idr_r, last_levels, imr_r, rise_en, fall_en, pend_r;

  int  fail_count;
  int  items_sent;
  int  results_checked;
  int  irq_seen;
  int  bad_seen;
  int  sample_count;
  int  cycle_count;
  bit  quiet_span;
  logic [PINS_W-1:0] pad_levels_now;

  gpio_port_with_edge_interrupts_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic item_t make_item(input logic [KIND_W-1:0] kind,
                                      input logic [INDEX_W-1:0] idx,
                                      input logic [WORD_W-1:0] wd,
                                      input logic [PINS_W-1:0] lv);
    item_t it;
    it.kind       = kind;
    it.reg_index  = idx;
    it.write_data = wd;
    it.pin_levels = lv;
    return it;
  endfunction

  function automatic result_t make_result(input logic [WORD_W-1:0] rd,
                                          input logic [PINS_W-1:0] pad,
                                          input logic [PINS_W-1:0] pde,
                                          input logic irq, input logic bad);
    result_t r;
    r.read_data        = rd;
    r.pad_out          = pad;
    r.pad_drive_enable = pde;
    r.irq              = irq;
    r.bad_address      = bad;
    return r;
  endfunction

  // Apply one item to the shadow registers and return the port's response
  function automatic result_t predict_port_result(input item_t it);
    logic [PINS_W-1:0] lv;
    result_t r;
    int p;
    r  = '0;
    lv = it.pin_levels & PIN_MASK;
    if (it.kind == KIND_READ || it.kind == KIND_WRITE) begin
      if (it.reg_index > REG_PENDING) begin
        r.bad_address = 1'b1;
      end else if (it.kind == KIND_READ) begin
        case (it.reg_index)
          REG_MODE:  r.read_data = mode_r;
          REG_OTYPE: r.read_data = WORD_W'(otype_r);
          REG_SPEED: r.read_data = speed_r;
          REG_PULL:  r.read_data = pull_r;
          REG_IDR:   r.read_data = WORD_W'(idr_r);
          REG_ODR:   r.read_data = WORD_W'(odr_r);
          REG_AFL:   r.read_data = afr_lo;
          REG_AFH:   r.read_data = afr_hi;
          REG_IMR:   r.read_data = WORD_W'(imr_r);
          REG_RISE:  r.read_data = WORD_W'(rise_en);
          REG_FALL:  r.read_data = WORD_W'(fall_en);
          default:   r.read_data = WORD_W'(pend_r);
        endcase
      end else begin
        case (it.reg_index)
          REG_MODE:  mode_r  = it.write_data & PAIR_MASK;
          REG_OTYPE: otype_r = it.write_data[PINS_W-1:0] & PIN_MASK;
          REG_SPEED: speed_r = it.write_data & PAIR_MASK;
          REG_PULL:  pull_r  = it.write_data & PAIR_MASK;
          REG_IDR:   ;
          REG_ODR:   odr_r   = it.write_data[PINS_W-1:0] & PIN_MASK;
          REG_AFL:   afr_lo  = it.write_data & AF0_MASK;
          REG_AFH:   afr_hi  = it.write_data & AF1_MASK;
          REG_IMR:   imr_r   = it.write_data[PINS_W-1:0] & PIN_MASK;
          REG_RISE:  rise_en = it.write_data[PINS_W-1:0] & PIN_MASK;
          REG_FALL:  fall_en = it.write_data[PINS_W-1:0] & PIN_MASK;
          default:   pend_r  = pend_r & ~(it.write_data[PINS_W-1:0] & PIN_MASK);
        endcase
      end
    end else if (it.kind == KIND_SAMPLE) begin
      // Latch edges against the previous sample
      pend_r = pend_r | ((((lv & ~last_levels) & rise_en) |
                          ((last_levels & ~lv) & fall_en)) & PIN_MASK);
      idr_r       = lv;
      last_levels = lv;
    end
    r.pad_out = odr_r;
    for (p = 0; p < PIN_COUNT; p++)
      r.pad_drive_enable[p] = (mode_r[2*p +: 2] == MODE_OUTPUT);
    r.irq = |(pend_r & imr_r);
    return r;
  endfunction

  function automatic int draw_gap();
    return quiet_span ? 0 : $urandom_range(5, 0);
  endfunction

  function automatic void add_row(input item_t it, input bit typed, input result_t golden);
    directed_row_t row;
    row.it     = it;
    row.typed  = typed;
    row.golden = golden;
    directed_rows.push_back(row);
  endfunction

  // Present one item, hold it until accepted, then queue its expected result
  task automatic send_item(input item_t it, input bit typed, input result_t golden);
    int gap;
    result_t predicted;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {4'b0, it.pin_levels, it.write_data, it.reg_index};
    do @(posedge clk); while (!in_tready);
    predicted = predict_port_result(it);
    port_results_q.push_back(typed ? golden : predicted);
    if (it.kind == KIND_SAMPLE) sample_count++;
    items_sent++;
  endtask

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: stall a random number of cycles before each item
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t act_r;
    result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      act_r = make_result(out_tdata[31:0], out_tdata[47:32], out_tdata[63:48],
                          out_tdata[64], out_tdata[65]);
      if (port_results_q.size() == 0) begin
        $error("result item with nothing expected: %h", out_tdata);
        fail_count++;
      end else begin
        exp_r = port_results_q.pop_front();
        results_checked++;
        if (act_r.irq) irq_seen++;
        if (act_r.bad_address) bad_seen++;
        if (act_r.read_data !== exp_r.read_data) begin
          $error("read_data: expected %h, got %h", exp_r.read_data, act_r.read_data);
          fail_count++;
        end
        if (act_r.pad_out !== exp_r.pad_out) begin
          $error("pad_out: expected %h, got %h", exp_r.pad_out, act_r.pad_out);
          fail_count++;
        end
        if (act_r.pad_drive_enable !== exp_r.pad_drive_enable) begin
          $error("pad_drive_enable: expected %h, got %h",
                 exp_r.pad_drive_enable, act_r.pad_drive_enable);
          fail_count++;
        end
        if (act_r.irq !== exp_r.irq) begin
          $error("irq: expected %b, got %b", exp_r.irq, act_r.irq);
          fail_count++;
        end
        if (act_r.bad_address !== exp_r.bad_address) begin
          $error("bad_address: expected %b, got %b", exp_r.bad_address, act_r.bad_address);
          fail_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int n_directed;
    int pick;
    int n;
    logic [INDEX_W-1:0] idx;
    logic [KIND_W-1:0]  kind;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = KIND_READ;
    out_tready = 1'b0;
    fail_count = 0;
    items_sent = 0;
    results_checked = 0;
    irq_seen   = 0;
    bad_seen   = 0;
    sample_count = 0;
    cycle_count  = 0;
    quiet_span   = 1'b0;
    pad_levels_now = '0;
    mode_r = '0; speed_r = '0; pull_r = '0; afr_lo = '0; afr_hi = '0;
    otype_r = '0; odr_r = '0; idr_r = '0; last_levels = '0;
    imr_r = '0; rise_en = '0; fall_en = '0; pend_r = '0;

    // Directed table: typed results only where obvious from reset state
    add_row(make_item(KIND_READ, REG_MODE, '1, '1), 1'b1,
            make_result('0, '0, '0, 1'b0, 1'b0));
    add_row(make_item(KIND_READ, REG_PENDING, '0, '0), 1'b1,
            make_result('0, '0, '0, 1'b0, 1'b0));
    add_row(make_item(KIND_READ, REG_TOP, '1, '1), 1'b1,
            make_result('0, '0, '0, 1'b0, 1'b1));
    add_row(make_item(KIND_WRITE, REG_PENDING + 4'd1, '1, '1), 1'b1,
            make_result('0, '0, '0, 1'b0, 1'b1));
    add_row(make_item(KIND_UNUSED, REG_MODE, '1, '1), 1'b1,
            make_result('0, '0, '0, 1'b0, 1'b0));
    add_row(make_item(KIND_WRITE, REG_MODE, 32'h5555_5555, '0), 1'b1,
            make_result('0, '0, 16'hFFFF, 1'b0, 1'b0));
    add_row(make_item(KIND_WRITE, REG_ODR, '1, '0), 1'b1,
            make_result('0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
    add_row(make_item(KIND_READ, REG_ODR, '0, '0), 1'b0, '0);
    add_row(make_item(KIND_WRITE, REG_IDR, '1, '1), 1'b0, '0);
    add_row(make_item(KIND_READ, REG_IDR, '0, '0), 1'b0, '0);
    add_row(make_item(KIND_WRITE, REG_OTYPE, '1, '0), 1'b0, '0);
    add_row(make_item(KIND_WRITE, REG_SPEED, '1, '0), 1'b0, '0);
    add_row(make_item(KIND_WRITE, REG_PULL, '1, '0), 1'b0, '0);
    add_row(make_item(KIND_WRITE, REG_AFL, '1, '0), 1'b0, '0);
    add_row(make_item(KIND_WRITE, REG_AFH, '1, '0), 1'b0, '0);
    add_row(make_item(KIND_READ, REG_AFH, '0, '0), 1'b0, '0);
    add_row(make_item(KIND_WRITE, REG_MODE, 32'hAAAA_AAAA, '0), 1'b0, '0);
    add_row(make_item(KIND_WRITE, REG_RISE, '1, '0), 1'b0, '0);
    add_row(make_item(KIND_WRITE, REG_IMR, '1, '0), 1'b0, '0);
    add_row(make_item(KIND_SAMPLE, REG_TOP, '1, '1), 1'b0, '0);
    add_row(make_item(KIND_READ, REG_PENDING, '0, '0), 1'b0, '0);
    add_row(make_item(KIND_WRITE, REG_FALL, '1, '0), 1'b0, '0);
    add_row(make_item(KIND_WRITE, REG_PENDING, '1, '0), 1'b0, '0);
    add_row(make_item(KIND_SAMPLE, REG_MODE, '0, '0), 1'b0, '0);
    add_row(make_item(KIND_WRITE, REG_PENDING, '0, '1), 1'b0, '0);
    add_row(make_item(KIND_WRITE, REG_IMR, '0, '0), 1'b0, '0);
    add_row(make_item(KIND_READ, REG_PENDING, '1, '1), 1'b0, '0);
    n_directed = directed_rows.size();

    // Hold reset, then release at a clock edge
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].golden);

    // Random part: interrupt sequences in half the rounds, some write/readback, some noise
    while (items_sent < n_directed + RANDOM_ITEMS) begin
      quiet_span = ($urandom_range(9, 0) < 2);
      pick = $urandom_range(9, 0);
      if (pick < 5) begin
        send_item(make_item(KIND_WRITE, REG_RISE, $urandom, 16'($urandom)), 1'b0, '0);
        send_item(make_item(KIND_WRITE, REG_FALL, $urandom, 16'($urandom)), 1'b0, '0);
        send_item(make_item(KIND_WRITE, REG_IMR, $urandom, 16'($urandom)), 1'b0, '0);
        n = $urandom_range(8, 2);
        repeat (n) begin
          // Mostly flip a few pins, sometimes jump to a fresh pattern
          if ($urandom_range(3, 0) == 0) pad_levels_now = 16'($urandom);
          else pad_levels_now = pad_levels_now ^ (16'($urandom) & 16'($urandom));
          send_item(make_item(KIND_SAMPLE, 4'($urandom), $urandom, pad_levels_now),
                    1'b0, '0);
        end
        send_item(make_item(KIND_READ, REG_PENDING, $urandom, 16'($urandom)), 1'b0, '0);
        send_item(make_item(KIND_WRITE, REG_PENDING, $urandom, 16'($urandom)), 1'b0, '0);
        send_item(make_item(KIND_READ, REG_PENDING, $urandom, 16'($urandom)), 1'b0, '0);
      end else if (pick < 7) begin
        idx = 4'($urandom_range(int'(REG_PENDING), int'(REG_MODE)));
        send_item(make_item(KIND_WRITE, idx, $urandom, 16'($urandom)), 1'b0, '0);
        send_item(make_item(KIND_READ, idx, $urandom, 16'($urandom)), 1'b0, '0);
      end else begin
        n = $urandom_range(6, 1);
        repeat (n) begin
          kind = 2'($urandom);
          idx  = ($urandom_range(7, 0) == 0) ?
                 4'($urandom_range(int'(REG_TOP), int'(REG_PENDING) + 1)) :
                 4'($urandom_range(int'(REG_PENDING), int'(REG_MODE)));
          if (kind == KIND_SAMPLE) pad_levels_now = 16'($urandom);
          send_item(make_item(kind, idx, $urandom, pad_levels_now), 1'b0, '0);
        end
      end
    end

    // Drain outstanding results
    in_tvalid <= 1'b0;
    while (port_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d items (%0d directed, %0d pin samples), %0d results compared",
             items_sent, n_directed, sample_count, results_checked);
    $display("Run: %0d results with irq high, %0d unmapped accesses", irq_seen, bad_seen);
    if (fail_count == 0 && port_results_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
